FILE: design/chrd_pkg.sv
// ----------------------------------------------------------------------------
// chrd_pkg
// shared constants, types and the chord shape table
// ----------------------------------------------------------------------------
package chrd_pkg;

  localparam int MAX_NOTES   = 12;
  localparam int CNT_W       = $clog2(MAX_NOTES + 1);
  localparam int IDX_W       = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int TABLE_SIZE  = 127;
  localparam logic [7:0] STOP_NOTE = 8'd112;
  localparam logic [7:0] OCTAVE    = 8'd12;

  typedef logic [11:0] pcset_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // store incoming note
    logic start;     // copy store to work set, reset scan
    logic find_min;  // step min scan one note
    logic build;     // form pitch class set from current min
    logic match;     // compare against one table entry
    logic raise;     // raise lowest note by an octave
    logic done;      // clear chord once the result is taken
  } chrd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_end;   // min scan covered all notes
    logic stop;       // first note (at start) or raised note at or above stop note
    logic tbl_end;    // last table entry compared
    logic hit;        // named entry matched
    logic empty_bad;  // no notes or too many
  } chrd_sts_t;

  function automatic pcset_t shape_mask(input logic [6:0] k);
    pcset_t m;
    case (k)
      7'd0: m = 12'h001; 7'd1: m = 12'h003; 7'd2: m = 12'h005; 7'd3: m = 12'h009;
      7'd4: m = 12'h011; 7'd5: m = 12'h009; 7'd6: m = 12'h021; 7'd7: m = 12'h041;
      7'd8: m = 12'h081; 7'd9: m = 12'h101; 7'd10: m = 12'h201; 7'd11: m = 12'h401;
      7'd12: m = 12'h801;
      7'd26: m = 12'h091; 7'd27: m = 12'h291; 7'd28: m = 12'h295; 7'd29: m = 12'h891;
      7'd30: m = 12'h811; 7'd31: m = 12'h911; 7'd32: m = 12'h851; 7'd33: m = 12'h8D1;
      7'd34: m = 12'h895; 7'd35: m = 12'h815; 7'd36: m = 12'h915; 7'd37: m = 12'h855;
      7'd38: m = 12'h8D5; 7'd39: m = 12'h8B5; 7'd40: m = 12'h835; 7'd41: m = 12'h8B1;
      7'd42: m = 12'h831; 7'd43: m = 12'hAB5; 7'd44: m = 12'hA35; 7'd45: m = 12'hAB1;
      7'd46: m = 12'hA31; 7'd47: m = 12'hA95; 7'd48: m = 12'hA15; 7'd49: m = 12'hA91;
      7'd50: m = 12'hA11; 7'd51: m = 12'hAD5; 7'd52: m = 12'hA55; 7'd53: m = 12'hAD1;
      7'd54: m = 12'hA51; 7'd55: m = 12'h095; 7'd56: m = 12'h089; 7'd57: m = 12'h289;
      7'd58: m = 12'h28D; 7'd59: m = 12'h489; 7'd60: m = 12'h409; 7'd61: m = 12'h509;
      7'd62: m = 12'h48B; 7'd63: m = 12'h589; 7'd64: m = 12'h48D; 7'd65: m = 12'h40D;
      7'd66: m = 12'h4AD; 7'd67: m = 12'h42D; 7'd68: m = 12'h4A9; 7'd69: m = 12'h429;
      7'd70: m = 12'h4AB; 7'd71: m = 12'h42B; 7'd72: m = 12'h5AD; 7'd73: m = 12'h52D;
      7'd74: m = 12'h5A9; 7'd75: m = 12'h529; 7'd76: m = 12'h5AB; 7'd77: m = 12'h52B;
      7'd78: m = 12'h6AD; 7'd79: m = 12'h62D; 7'd80: m = 12'h6A9; 7'd81: m = 12'h629;
      7'd82: m = 12'h68D; 7'd83: m = 12'h60D; 7'd84: m = 12'h689; 7'd85: m = 12'h609;
      7'd86: m = 12'h6AB; 7'd87: m = 12'h62B; 7'd88: m = 12'h68B; 7'd89: m = 12'h60B;
      7'd90: m = 12'h08D; 7'd91: m = 12'h449; 7'd92: m = 12'h111; 7'd93: m = 12'h049;
      7'd94: m = 12'h249; 7'd95: m = 12'h24D; 7'd96: m = 12'h26D; 7'd97: m = 12'h085;
      7'd98: m = 12'h0A1; 7'd99: m = 12'h491; 7'd100: m = 12'h411; 7'd101: m = 12'h451;
      7'd102: m = 12'h511; 7'd103: m = 12'h493; 7'd104: m = 12'h413; 7'd105: m = 12'h499;
      7'd106: m = 12'h419; 7'd107: m = 12'h453; 7'd108: m = 12'h459; 7'd109: m = 12'h519;
      7'd110: m = 12'h513; 7'd111: m = 12'h495; 7'd112: m = 12'h415; 7'd113: m = 12'h455;
      7'd114: m = 12'h515; 7'd115: m = 12'h4B5; 7'd116: m = 12'h435; 7'd117: m = 12'h4B1;
      7'd118: m = 12'h431; 7'd119: m = 12'h6B5; 7'd120: m = 12'h635; 7'd121: m = 12'h6B1;
      7'd122: m = 12'h631; 7'd123: m = 12'h695; 7'd124: m = 12'h615; 7'd125: m = 12'h691;
      7'd126: m = 12'h611;
      default: m = 12'h000;
    endcase
    return m;
  endfunction

  // pitch class of a value below 256 by reciprocal and one correction
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] q;
    logic [7:0]  r;
    q = (16'(v) * 16'd21) >> 8;
    r = v - 8'(q[7:0] * 8'd12);
    if (r >= OCTAVE) r = r - OCTAVE;
    return r[3:0];
  endfunction

endpackage

FILE: design/chrd_ctrl.sv
// ----------------------------------------------------------------------------
// chrd_ctrl
// controller state machine sequencing load, scan, build, match and raise
// ----------------------------------------------------------------------------
module chrd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output chrd_pkg::chrd_cmd_t cmd,
  input  chrd_pkg::chrd_sts_t sts
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MIN   = 3'd2;
  localparam logic [2:0] S_BUILD = 3'd3;
  localparam logic [2:0] S_MATCH = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign acc       = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_LOAD: begin
        if (acc) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (sts.empty_bad || sts.stop) state_nxt = S_OUT;
        else state_nxt = S_MIN;
      end
      S_MIN: begin
        cmd.find_min = 1'b1;
        if (sts.scan_end) state_nxt = S_BUILD;
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = S_MATCH;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        if (sts.hit) begin
          state_nxt = S_OUT;
        end else if (sts.tbl_end) begin
          cmd.raise = 1'b1;
          if (sts.stop) state_nxt = S_OUT;
          else state_nxt = S_MIN;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.done = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else state_r <= state_nxt;
  end

endmodule

FILE: design/chrd_dp.sv
// ----------------------------------------------------------------------------
// chrd_dp
// datapath: note store, work set, min scan, pitch class set, table compare
// ----------------------------------------------------------------------------
module chrd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [6:0]         in_note,
  input  chrd_pkg::chrd_cmd_t cmd,
  output chrd_pkg::chrd_sts_t sts,
  output logic               out_found,
  output logic [6:0]         out_chord_entry,
  output logic [3:0]         out_root_class,
  output logic               out_slash,
  output logic [3:0]         out_bass_class
);

  logic [6:0] store_r [chrd_pkg::MAX_NOTES];
  logic [7:0] work_r  [chrd_pkg::MAX_NOTES];
  logic [chrd_pkg::CNT_W-1:0] cnt_r;
  logic [6:0] first_r;
  logic       many_r;
  logic [chrd_pkg::IDX_W-1:0] scan_r, min_idx_r;
  logic [7:0] min_val_r;
  chrd_pkg::pcset_t set_r;
  logic [6:0] k_r;
  logic [3:0] base_cls_r;
  logic       found_r, slash_r;
  logic [6:0] entry_r;
  logic [3:0] root_r, bass_r;

  logic [7:0] cur, raised;
  logic       is_last_scan, hit;
  logic [7:0] new_min;

  assign cur          = work_r[scan_r];
  assign is_last_scan = ({1'b0, scan_r} == (chrd_pkg::CNT_W+1)'(cnt_r - 1'b1));
  assign new_min      = (scan_r == '0 || cur < min_val_r) ? cur : min_val_r;
  assign hit          = (chrd_pkg::shape_mask(k_r) == set_r) && (k_r != 7'd0);
  assign raised       = work_r[min_idx_r] + chrd_pkg::OCTAVE;

  assign sts.scan_end  = is_last_scan;
  assign sts.tbl_end   = (k_r == 7'(chrd_pkg::TABLE_SIZE - 1));
  assign sts.hit       = hit;
  assign sts.empty_bad = many_r || (cnt_r == '0);
  // start tests first note, later tests test the raised note
  assign sts.stop      = cmd.match ? (raised >= chrd_pkg::STOP_NOTE)
                                   : ({1'b0, first_r} >= chrd_pkg::STOP_NOTE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      many_r  <= 1'b0;
      first_r <= '0;
    end else if (cmd.load) begin
      if (cnt_r == '0) first_r <= in_note;
      if (cnt_r < chrd_pkg::CNT_W'(chrd_pkg::MAX_NOTES)) cnt_r <= cnt_r + 1'b1;
      else many_r <= 1'b1;
    end else if (cmd.done) begin
      cnt_r  <= '0;
      many_r <= 1'b0;
    end
  end

  // store, work set and search registers
  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r < chrd_pkg::CNT_W'(chrd_pkg::MAX_NOTES))
      store_r[cnt_r[chrd_pkg::IDX_W-1:0]] <= in_note;
    if (cmd.start) begin
      for (int i = 0; i < chrd_pkg::MAX_NOTES; i++) work_r[i] <= {1'b0, store_r[i]};
      scan_r  <= '0;
      found_r <= 1'b0;
      entry_r <= '0;
      root_r  <= '0;
      slash_r <= 1'b0;
      bass_r  <= '0;
    end
    if (cmd.find_min) begin
      min_val_r <= new_min;
      if (scan_r == '0 || cur < min_val_r) min_idx_r <= scan_r;
      scan_r <= is_last_scan ? '0 : scan_r + 1'b1;
    end
    // pitch class set relative to lowest note, one note per lane
    if (cmd.build) begin
      for (int i = 0; i < chrd_pkg::MAX_NOTES; i++)
        if (i < int'(cnt_r))
          set_r[chrd_pkg::mod12(work_r[i] - min_val_r)] <= 1'b1;
      base_cls_r <= chrd_pkg::mod12(min_val_r);
      k_r <= '0;
    end
    if (cmd.match) begin
      k_r <= k_r + 1'b1;
      if (hit) begin
        found_r <= 1'b1;
        entry_r <= k_r;
        root_r  <= base_cls_r;
        if (min_val_r != {1'b0, first_r}) begin
          slash_r <= 1'b1;
          bass_r  <= chrd_pkg::mod12({1'b0, first_r});
        end
      end
    end
    if (cmd.raise) work_r[min_idx_r] <= raised;
    if (cmd.find_min && scan_r == '0) set_r <= '0;
  end

  assign out_found       = found_r;
  assign out_chord_entry = entry_r;
  assign out_root_class  = root_r;
  assign out_slash       = slash_r;
  assign out_bass_class  = bass_r;

endmodule

FILE: design/chord_recognizer_unit.sv
// ----------------------------------------------------------------------------
// chord_recognizer_unit
// names a held chord from up to twelve loaded notes
// ----------------------------------------------------------------------------
// channel | ports                                   | direction
// in      | in_valid in_stall in_note in_last       | note items in
// out     | out_valid out_stall out_found ..bass    | one result per last item
// a plain note is stored as it is taken; a last note starts a search: a start,
// then per step a min scan over the held notes, one build and up to 127 compares
// (the table compare unit, one entry a cycle), and without a hit a raise of the
// lowest note by an octave, until a hit or a raised note reaches the stop note
// reset clears counts and the controller; the store needs no clearing
// while searching or holding a result the input is stalled
module chord_recognizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [6:0] in_note,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_found,
  output logic [6:0] out_chord_entry,
  output logic [3:0] out_root_class,
  output logic       out_slash,
  output logic [3:0] out_bass_class
);

  chrd_pkg::chrd_cmd_t cmd;
  chrd_pkg::chrd_sts_t sts;

  chrd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last, .out_valid, .out_stall,
    .cmd, .sts
  );

  chrd_dp u_dp (
    .clk, .rst_n, .in_note, .cmd, .sts, .out_found, .out_chord_entry,
    .out_root_class, .out_slash, .out_bass_class
  );

endmodule

FILE: design/chrd_checker.sv
// ----------------------------------------------------------------------------
// chrd_checker
// port level checks on the chord recognizer
// ----------------------------------------------------------------------------
module chrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_found,
  input logic [6:0] out_chord_entry,
  input logic [3:0] out_root_class,
  input logic       out_slash
);

  // no new item while a result is offered
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during result");

  // a last item starts a search, no result in the next cycle
  a_last_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> (in_stall && !out_valid))
    else $error("no search after last item");

  // a miss reports zero entry, root and slash fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_chord_entry == 7'd0 && out_root_class == 4'd0
      && !out_slash)) else $error("miss with nonzero fields");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_chord_entry)))
    else $error("stalled result changed");

endmodule

bind chord_recognizer_unit chrd_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_last, .out_valid, .out_stall,
  .out_found, .out_chord_entry, .out_root_class, .out_slash
);

FILE: sim/chord_recognizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chord_recognizer_unit_test
// loads note items into the chord recognizer and checks every result against
// a cycle-free predictor, or for typed directed rows against their given name:
// a short table of directed chords first, then random chords built from the
// shape table mixed with random noise, under random idling on both channels
// and one long stall stretch
module chord_recognizer_unit_test;

  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2000;

  // chord shapes as pitch class sets, in table order
  localparam bit [11:0] SHAPES [chrd_pkg::TABLE_SIZE] = '{
    12'h001,
    12'h003, 12'h005, 12'h009, 12'h011, 12'h009, 12'h021, 12'h041, 12'h081, 12'h101, 12'h201,
    12'h401, 12'h801, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    12'h091, 12'h291, 12'h295, 12'h891, 12'h811, 12'h911, 12'h851, 12'h8D1, 12'h895, 12'h815,
    12'h915, 12'h855, 12'h8D5, 12'h8B5, 12'h835, 12'h8B1, 12'h831, 12'hAB5, 12'hA35, 12'hAB1,
    12'hA31, 12'hA95, 12'hA15, 12'hA91, 12'hA11, 12'hAD5, 12'hA55, 12'hAD1, 12'hA51, 12'h095,
    12'h089, 12'h289, 12'h28D, 12'h489, 12'h409, 12'h509, 12'h48B, 12'h589, 12'h48D, 12'h40D,
    12'h4AD, 12'h42D, 12'h4A9, 12'h429, 12'h4AB, 12'h42B, 12'h5AD, 12'h52D, 12'h5A9, 12'h529,
    12'h5AB, 12'h52B, 12'h6AD, 12'h62D, 12'h6A9, 12'h629, 12'h68D, 12'h60D, 12'h689, 12'h609,
    12'h6AB, 12'h62B, 12'h68B, 12'h60B, 12'h08D, 12'h449,
    12'h111,
    12'h049, 12'h249, 12'h24D, 12'h26D,
    12'h085, 12'h0A1,
    12'h491, 12'h411, 12'h451, 12'h511, 12'h493, 12'h413, 12'h499, 12'h419, 12'h453, 12'h459,
    12'h519, 12'h513, 12'h495, 12'h415, 12'h455, 12'h515, 12'h4B5, 12'h435, 12'h4B1, 12'h431,
    12'h6B5, 12'h635, 12'h6B1, 12'h631, 12'h695, 12'h615, 12'h691, 12'h611
  };

  typedef struct packed {
    logic       found;
    logic [6:0] entry;
    logic [3:0] root;
    logic       slash;
    logic [3:0] bass;
  } chord_name_t;

  typedef struct {
    logic [6:0]  note;
    logic        last;
    bit          typed;
    chord_name_t name;
  } note_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [6:0] in_note;
  logic       in_last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_found;
  logic [6:0] out_chord_entry;
  logic [3:0] out_root_class;
  logic       out_slash;
  logic [3:0] out_bass_class;

  chord_recognizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_note(in_note), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_chord_entry(out_chord_entry), .out_root_class(out_root_class),
    .out_slash(out_slash), .out_bass_class(out_bass_class)
  );

  // predictor copy of the chord being loaded
  int unsigned held_notes [chrd_pkg::MAX_NOTES];
  int unsigned held_count;
  int unsigned bass_note;
  bit          overflowed;

  chord_name_t pending_names [$];
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  bit          hold_toggle;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // name the chord held in the predictor, then start a new chord
  function automatic chord_name_t name_chord();
    chord_name_t r;
    int unsigned w [chrd_pkg::MAX_NOTES];
    int unsigned probe, v, j, k;
    bit [11:0]   pcs;
    int          hit;
    r = '0;
    for (int i = 0; i < chrd_pkg::MAX_NOTES; i++) w[i] = held_notes[i];
    if (!overflowed && held_count > 0) begin
      probe = w[0];
      while (probe < chrd_pkg::STOP_NOTE) begin
        // insertion sort, lowest first
        for (int i = 1; i < held_count; i++) begin
          v = w[i];
          j = i;
          while (j > 0 && w[j-1] > v) begin
            w[j] = w[j-1];
            j--;
          end
          w[j] = v;
        end
        pcs = '0;
        for (int i = 0; i < held_count; i++)
          pcs[(w[i] - w[0]) % chrd_pkg::OCTAVE] = 1'b1;
        hit = 0;
        for (k = 0; k < chrd_pkg::TABLE_SIZE; k++) begin
          if (SHAPES[k] == pcs) begin
            hit = k;
            break;
          end
        end
        if (hit != 0) begin
          r.found = 1'b1;
          r.entry = 7'(hit);
          r.root  = 4'(w[0] % chrd_pkg::OCTAVE);
          if (w[0] != bass_note) begin
            r.slash = 1'b1;
            r.bass  = 4'(bass_note % chrd_pkg::OCTAVE);
          end
          break;
        end
        w[0] = w[0] + chrd_pkg::OCTAVE;
        probe = w[0];
      end
    end
    held_count = 0;
    overflowed = 1'b0;
    return r;
  endfunction

  // offer one note item and wait for it to be taken
  task automatic send_note(input logic [6:0] note, input logic last,
                           input bit typed, input chord_name_t name);
    bit taken;
    chord_name_t predicted;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_note  <= note;
    in_last  <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (held_count == 0) bass_note = note;
    if (held_count < chrd_pkg::MAX_NOTES) begin
      held_notes[held_count] = note;
      held_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (last) begin
      predicted = name_chord();
      pending_names.push_back(typed ? name : predicted);
    end
  endtask

  // one chord: a table shape on a random root, or random noise
  task automatic send_chord(output int unsigned sent_cnt);
    int unsigned notes [16];
    int unsigned cnt, root, k, t, s;
    bit [11:0]   pcs;
    cnt = 0;
    if ($urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, 126);
      pcs = SHAPES[k];
      if (pcs == 0) pcs = SHAPES[$urandom_range(26, 126)];
      root = $urandom_range(0, 116);
      for (int b = 0; b < 12; b++) begin
        if (pcs[b]) begin
          t = root + b + chrd_pkg::OCTAVE * $urandom_range(0, 1);
          if (t > 127) t = t - chrd_pkg::OCTAVE;
          notes[cnt] = t;
          cnt++;
        end
      end
    end else begin
      cnt = $urandom_range(1, 15);
      for (int i = 0; i < cnt; i++) notes[i] = $urandom_range(0, 127);
    end
    // shuffle so the bass is not always the root
    for (int i = cnt - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      t = notes[i];
      notes[i] = notes[s];
      notes[s] = t;
    end
    for (int i = 0; i < cnt; i++) send_note(7'(notes[i]), i == cnt - 1, 1'b0, '0);
    sent_cnt = cnt;
  endtask

  // receiver: random stall, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result check and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    chord_name_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_found, out_chord_entry, out_root_class, out_slash, out_bass_class};
      if (pending_names.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_names.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    note_row_t rows [$];
    int sent;
    int unsigned chord_len;
    bit held_off;
    bit drained;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_note = '0;
    in_last = 1'b0;
    held_count = 0;
    bass_note = 0;
    overflowed = 1'b0;
    mismatches = 0;
    idle_pct = 13;
    stall_pct = 53;
    hold_toggle = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed chords
    rows.push_back('{7'd0,   1'b1, 1'b1, chord_name_t'('0)});  // lone note never named
    rows.push_back('{7'd127, 1'b1, 1'b1, chord_name_t'('0)});  // at stop note at once
    rows.push_back('{7'd60,  1'b0, 1'b0, chord_name_t'('0)});
    rows.push_back('{7'd64,  1'b0, 1'b0, chord_name_t'('0)});
    rows.push_back('{7'd67,  1'b1, 1'b1, chord_name_t'{1'b1, 7'd26, 4'd0, 1'b0, 4'd0}});
    rows.push_back('{7'd64,  1'b0, 1'b0, chord_name_t'('0)});  // slash chord
    rows.push_back('{7'd60,  1'b0, 1'b0, chord_name_t'('0)});
    rows.push_back('{7'd67,  1'b1, 1'b1, chord_name_t'{1'b1, 7'd26, 4'd0, 1'b1, 4'd4}});
    rows.push_back('{7'd57,  1'b0, 1'b0, chord_name_t'('0)});
    rows.push_back('{7'd60,  1'b0, 1'b0, chord_name_t'('0)});
    rows.push_back('{7'd64,  1'b1, 1'b1, chord_name_t'{1'b1, 7'd56, 4'd9, 1'b0, 4'd0}});
    // thirteen notes overflow the store
    for (int i = 0; i < 13; i++)
      rows.push_back('{7'(i), i == 12, i == 12, chord_name_t'('0)});
    rows.push_back('{7'd115, 1'b0, 1'b0, chord_name_t'('0)});  // first note above stop note, never searched
    rows.push_back('{7'd100, 1'b1, 1'b0, chord_name_t'('0)});
    foreach (rows[i]) send_note(rows[i].note, rows[i].last, rows[i].typed, rows[i].name);

    // random chords under the three idling mixes, counted in note items
    sent = 0;
    held_off = 1'b0;
    drained = 1'b0;
    while (sent < 1620) begin
      if (sent >= 1080) begin
        idle_pct = 0;
        stall_pct = 0;
      end else if (sent >= 540) begin
        idle_pct = 53;
        stall_pct = 13;
      end
      if (!held_off && sent >= 300) begin
        hold_toggle = !hold_toggle;
        held_off = 1'b1;
      end
      if (!drained && sent >= 800) begin
        // let the block drain completely
        in_valid <= 1'b0;
        while (pending_names.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      send_chord(chord_len);
      sent += chord_len;
    end
    in_valid <= 1'b0;

    while (pending_names.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_names.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
